// File: src/bap_pkg.sv
`timescale 1ns / 1ps
package bap_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd2;

  localparam int CFG_DATA_W = 13;
  localparam int PIX_W = 8;
  localparam int SUM_W = 24;
  localparam int POS_W = 13;
  localparam int BLK_W = 11;
  localparam int MAX_REGION_WIDTH = 4096;
  localparam int MAX_REGION_HEIGHT = 4096;

  // Block pixel count fits 16 bits for block sizes up to 255.
  localparam int CNT_W = 16;

  typedef struct packed {
    logic             first;
    logic             emit;
    logic             last;
    logic [BLK_W-1:0] bcol;
    logic [BLK_W-1:0] brow;
    logic [CNT_W-1:0] cnt;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
    logic [BLK_W-1:0] bcol;
    logic [BLK_W-1:0] brow;
    logic             last;
  } res_t;

endpackage

// File: src/bap_ram.sv
`timescale 1ns / 1ps
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bap_front.sv
`timescale 1ns / 1ps
module bap_front #(
  parameter int MAX_BLOCK_SIZE   = 200
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bap_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bap_pkg::CFG_DATA_W-1:0]   cfg_dat,
  input  logic                             pix_valid,
  input  logic [bap_pkg::PIX_W-1:0]        pix_red,
  input  logic [bap_pkg::PIX_W-1:0]        pix_green,
  input  logic [bap_pkg::PIX_W-1:0]        pix_blue,
  input  logic [bap_pkg::PIX_W-1:0]        pix_alpha,
  output bap_pkg::cmd_t                    cmd
);

  localparam int PW = bap_pkg::POS_W;
  localparam int BW = bap_pkg::BLK_W;

  logic [12:0] width_r, height_r;
  logic [7:0]  bsize_r;
  logic [PW-1:0] w_c, h_c;
  logic [7:0]    bs_c;

  // Position is tracked incrementally: block index plus offset in block.
  logic [PW-1:0] x_r, y_r;
  logic [7:0]    ix_r, iy_r;
  logic [BW-1:0] bcol_r, brow_r;
  logic [PW-1:0] bx0_r, by0_r;
  logic [PW-1:0] bwid, bhgt;
  logic          end_x, end_y;
  logic          cfg_hit;

  assign cfg_hit = cfg_we && (cfg_idx == bap_pkg::REG_REGION_WIDTH ||
                              cfg_idx == bap_pkg::REG_REGION_HEIGHT ||
                              cfg_idx == bap_pkg::REG_BLOCK_SIZE);

  always_comb begin
    w_c = (width_r == '0) ? PW'(1) :
          (width_r > PW'(bap_pkg::MAX_REGION_WIDTH)) ? PW'(bap_pkg::MAX_REGION_WIDTH) :
          PW'(width_r);
    h_c = (height_r == '0) ? PW'(1) :
          (height_r > PW'(bap_pkg::MAX_REGION_HEIGHT)) ?
          PW'(bap_pkg::MAX_REGION_HEIGHT) : PW'(height_r);
    bs_c = (bsize_r < 8'd2) ? 8'd2 :
           (bsize_r > 8'(MAX_BLOCK_SIZE)) ? 8'(MAX_BLOCK_SIZE) : bsize_r;
    end_x = (x_r == w_c - PW'(1));
    end_y = (y_r == h_c - PW'(1));
    bwid = ((w_c - bx0_r) > PW'(bs_c)) ? PW'(bs_c) : (w_c - bx0_r);
    bhgt = ((h_c - by0_r) > PW'(bs_c)) ? PW'(bs_c) : (h_c - by0_r);
    cmd.first = pix_valid && ix_r == '0 && iy_r == '0;
    cmd.emit  = pix_valid && (ix_r == bs_c - 8'd1 || end_x) &&
                (iy_r == bs_c - 8'd1 || end_y);
    cmd.last  = end_x && end_y;
    cmd.bcol  = bcol_r;
    cmd.brow  = brow_r;
    cmd.cnt   = 16'(bwid[7:0]) * 16'(bhgt[7:0]);
    cmd.red   = pix_red;
    cmd.green = pix_green;
    cmd.blue  = pix_blue;
    cmd.alpha = pix_alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 13'd64;
      height_r <= 13'd64;
      bsize_r <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bap_pkg::REG_REGION_WIDTH:  width_r <= cfg_dat;
        bap_pkg::REG_REGION_HEIGHT: height_r <= cfg_dat;
        bap_pkg::REG_BLOCK_SIZE:    bsize_r <= cfg_dat[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      x_r <= '0; y_r <= '0; ix_r <= '0; iy_r <= '0;
      bcol_r <= '0; brow_r <= '0; bx0_r <= '0; by0_r <= '0;
    end else if (pix_valid) begin
      if (end_x) begin
        x_r <= '0; ix_r <= '0; bcol_r <= '0; bx0_r <= '0;
        if (end_y) begin
          y_r <= '0; iy_r <= '0; brow_r <= '0; by0_r <= '0;
        end else begin
          y_r <= y_r + PW'(1);
          if (iy_r == bs_c - 8'd1) begin
            iy_r <= '0;
            brow_r <= brow_r + BW'(1);
            by0_r <= by0_r + PW'(bs_c);
          end else begin
            iy_r <= iy_r + 8'd1;
          end
        end
      end else begin
        x_r <= x_r + PW'(1);
        if (ix_r == bs_c - 8'd1) begin
          ix_r <= '0;
          bcol_r <= bcol_r + BW'(1);
          bx0_r <= bx0_r + PW'(bs_c);
        end else begin
          ix_r <= ix_r + 8'd1;
        end
      end
    end
  end

endmodule

// File: src/bap_back.sv
`timescale 1ns / 1ps
module bap_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  bap_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          res_valid,
  output bap_pkg::res_t res,
  input  logic          res_ready
);

  localparam int SDEPTH = bap_pkg::MAX_REGION_WIDTH / 2;
  localparam int AW = $clog2(SDEPTH);
  localparam int SW = bap_pkg::SUM_W;
  localparam int CW = bap_pkg::CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_r;
  bap_pkg::cmd_t c_r;
  logic [4*SW-1:0] rd;
  logic [4*SW-1:0] wd;
  logic            we;
  logic [SW-1:0]   sum_r [4];
  logic [SW-1:0]   rem_r [4];
  logic [4:0]      step_r;
  logic            res_valid_r;
  bap_pkg::res_t   res_r;
  logic            out_load;

  assign cmd_ready = (state_r == ST_IDLE);
  assign res_valid = res_valid_r;
  assign res = res_r;
  assign out_load = (state_r == ST_OUT) && (!res_valid_r || res_ready);

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_ch
      logic [SW-1:0] pix;
      assign pix = SW'(c_r[g*bap_pkg::PIX_W +: bap_pkg::PIX_W]);
      assign wd[g*SW +: SW] = c_r.first ? pix : rd[g*SW +: SW] + pix;
      bap_ram #(.WIDTH(SW), .DEPTH(SDEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(c_r.bcol[AW-1:0]), .wdata(wd[g*SW +: SW]),
        .raddr(c_r.bcol[AW-1:0]), .rdata(rd[g*SW +: SW])
      );
    end
  endgenerate

  assign we = (state_r == ST_ACC);

  // Restoring division: quotient below 256, so eight steps suffice.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: if (cmd_valid && cmd_ready) begin
          c_r <= cmd;
          state_r <= ST_READ;
        end
        ST_READ: state_r <= ST_ACC;
        ST_ACC: begin
          for (int k = 0; k < 4; k++) begin
            rem_r[k] <= wd[k*SW +: SW];
          end
          step_r <= 5'd7;
          state_r <= c_r.emit ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          for (int k = 0; k < 4; k++) begin
            if ((SW+CW)'(rem_r[k]) >= ((SW+CW)'(c_r.cnt) << step_r)) begin
              rem_r[k] <= rem_r[k] - SW'((SW+CW)'(c_r.cnt) << step_r);
              sum_r[k] <= {sum_r[k][SW-2:0], 1'b1};
            end else begin
              sum_r[k] <= {sum_r[k][SW-2:0], 1'b0};
            end
          end
          if (step_r == 5'd0) begin
            state_r <= ST_OUT;
          end
          step_r <= step_r - 5'd1;
        end
        ST_OUT: if (out_load) begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (out_load) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_r.red   <= sum_r[3][7:0];
      res_r.green <= sum_r[2][7:0];
      res_r.blue  <= sum_r[1][7:0];
      res_r.alpha <= sum_r[0][7:0];
      res_r.bcol  <= c_r.bcol;
      res_r.brow  <= c_r.brow;
      res_r.last  <= c_r.last;
    end
  end

endmodule

// File: src/block_average_pixelate.sv
`timescale 1ns / 1ps
// A pixel enters the input queue, then holds the back end through issue, sum read and sum
// write back; a block-completing pixel then also passes through the divider and the
// output stage, which waits until the result register is free or being read. The back
// end takes a new pixel from the queue only when idle, not while one is still in flight.
// Synchronous active-low reset restores default registers; sum memory is not cleared.
module block_average_pixelate #(
  parameter int MAX_BLOCK_SIZE   = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_pix_red,
  input  logic [7:0]  in_pix_green,
  input  logic [7:0]  in_pix_blue,
  input  logic [7:0]  in_pix_alpha,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_avg_red,
  output logic [7:0]  out_avg_green,
  output logic [7:0]  out_avg_blue,
  output logic [7:0]  out_avg_alpha,
  output logic [10:0] out_block_col,
  output logic [10:0] out_block_row,
  output logic        out_last_block
);

  bap_pkg::cmd_t cmd, q_r [2];
  logic [1:0] cnt_r;
  logic       rd_ptr_r, wr_ptr_r;
  logic       push, pop, b_ready, res_valid;
  bap_pkg::res_t res;

  assign cfg_ready = 1'b1;
  assign in_full = (cnt_r == 2'd2);
  assign push = in_push && !in_full;
  assign pop = (cnt_r != 2'd0) && b_ready;

  bap_front #(.MAX_BLOCK_SIZE(MAX_BLOCK_SIZE)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_dat(cfg_data),
    .pix_valid(push), .pix_red(in_pix_red), .pix_green(in_pix_green),
    .pix_blue(in_pix_blue), .pix_alpha(in_pix_alpha), .cmd(cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_ptr_r <= 1'b0; wr_ptr_r <= 1'b0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= cmd;
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  bap_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cnt_r != 2'd0), .cmd(q_r[rd_ptr_r]),
    .cmd_ready(b_ready), .res_valid(res_valid), .res(res), .res_ready(out_pop)
  );

  assign out_empty      = !res_valid;
  assign out_avg_red    = res.red;
  assign out_avg_green  = res.green;
  assign out_avg_blue   = res.blue;
  assign out_avg_alpha  = res.alpha;
  assign out_block_col  = res.bcol;
  assign out_block_row  = res.brow;
  assign out_last_block = res.last;

endmodule

// File: sim/tb_block_average_pixelate.sv
`timescale 1ns / 1ps
module tb_block_average_pixelate;

  localparam int SUM_SLOTS = 2048;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1150;
  localparam logic [1:0] REG_NONE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_pix_red;
  logic [7:0]  in_pix_green;
  logic [7:0]  in_pix_blue;
  logic [7:0]  in_pix_alpha;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_avg_red;
  logic [7:0]  out_avg_green;
  logic [7:0]  out_avg_blue;
  logic [7:0]  out_avg_alpha;
  logic [10:0] out_block_col;
  logic [10:0] out_block_row;
  logic        out_last_block;

  block_average_pixelate dut (.*);

  logic [12:0] shadow_width;
  logic [12:0] shadow_height;
  logic [7:0]  shadow_bsize;
  int unsigned next_col;
  int unsigned next_row;
  logic [23:0] red_acc[SUM_SLOTS];
  logic [23:0] green_acc[SUM_SLOTS];
  logic [23:0] blue_acc[SUM_SLOTS];
  logic [23:0] alpha_acc[SUM_SLOTS];

  bap_pkg::res_t pending_avgs[$];
  int   errors;
  int   pixels_sent;
  bit   calm;
  bit   hold_request;
  int   hold_left;
  int   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 7);
  endfunction

  function automatic void model_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a);
    int unsigned w, h, bs, x, y, bcol, brow, ix, iy, slot, bw, bh, cnt;
    bap_pkg::res_t avg;
    w = clip(shadow_width, 1, 4096);
    h = clip(shadow_height, 1, bap_pkg::MAX_REGION_HEIGHT);
    bs = clip(shadow_bsize, 2, 200);
    if (next_col >= w) next_col = 0;
    if (next_row >= h) next_row = 0;
    x = next_col;
    y = next_row;
    bcol = x / bs;
    brow = y / bs;
    ix = x % bs;
    iy = y % bs;
    slot = bcol % SUM_SLOTS;
    if (ix == 0 && iy == 0) begin
      red_acc[slot] = 24'(r);
      green_acc[slot] = 24'(g);
      blue_acc[slot] = 24'(b);
      alpha_acc[slot] = 24'(a);
    end else begin
      red_acc[slot] = red_acc[slot] + 24'(r);
      green_acc[slot] = green_acc[slot] + 24'(g);
      blue_acc[slot] = blue_acc[slot] + 24'(b);
      alpha_acc[slot] = alpha_acc[slot] + 24'(a);
    end
    if ((ix == bs - 1 || x == w - 1) && (iy == bs - 1 || y == h - 1)) begin
      bw = w - bcol * bs;
      bh = h - brow * bs;
      if (bw > bs) bw = bs;
      if (bh > bs) bh = bs;
      cnt = bw * bh;
      if (cnt == 0) cnt = 1;
      avg.red = 8'(red_acc[slot] / cnt);
      avg.green = 8'(green_acc[slot] / cnt);
      avg.blue = 8'(blue_acc[slot] / cnt);
      avg.alpha = 8'(alpha_acc[slot] / cnt);
      avg.bcol = 11'(bcol);
      avg.brow = 11'(brow);
      avg.last = (x == w - 1 && y == h - 1);
      pending_avgs.push_back(avg);
    end
    next_col = x + 1;
    if (next_col >= w) begin
      next_col = 0;
      next_row = y + 1;
      if (next_row >= h) next_row = 0;
    end
  endfunction

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    while (take_break()) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_pix_red <= r;
    in_pix_green <= g;
    in_pix_blue <= b;
    in_pix_alpha <= a;
    do @(posedge clk); while (in_full);
    model_pixel(r, g, b, a);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic stop_sending();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bap_pkg::REG_REGION_WIDTH: shadow_width = value;
      bap_pkg::REG_REGION_HEIGHT: shadow_height = value;
      bap_pkg::REG_BLOCK_SIZE: shadow_bsize = value[7:0];
      default: ;
    endcase
    if (idx == bap_pkg::REG_REGION_WIDTH || idx == bap_pkg::REG_REGION_HEIGHT ||
        idx == bap_pkg::REG_BLOCK_SIZE) begin
      next_col = 0;
      next_row = 0;
    end
  endtask

  task automatic set_region(logic [12:0] w, logic [12:0] h, logic [12:0] bs);
    write_reg(bap_pkg::REG_REGION_WIDTH, w);
    write_reg(bap_pkg::REG_REGION_HEIGHT, h);
    write_reg(bap_pkg::REG_BLOCK_SIZE, bs);
  endtask

  task automatic test_reset_defaults();
    calm = 1'b1;
    repeat (80) send_random_pixel();
    calm = 1'b0;
  endtask

  task automatic test_channel_extremes();
    set_region(5, 3, 2);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'hFE, 8'h80, 8'h7F);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    repeat (20) send_random_pixel();
  endtask

  task automatic test_out_of_range_regs();
    set_region(0, 0, 0);
    repeat (3) send_random_pixel();
    set_region(3, 3, 1);
    repeat (10) send_random_pixel();
    write_reg(REG_NONE, 13'h1FFF);
    repeat (8) send_random_pixel();
    set_region(1, 8191, 13'h1FFF);
    repeat (220) send_random_pixel();
    set_region(8191, 1, 200);
    repeat (220) send_random_pixel();
    set_region(4096, 4096, 255);
    repeat (40) send_random_pixel();
  endtask

  task automatic test_full_input_stall();
    set_region(8, 8, 2);
    hold_request = 1'b1;
    repeat (64) send_random_pixel();
  endtask

  task automatic test_random_regions();
    int unsigned w, h, bs, count, iter;
    iter = 0;
    while (pixels_sent < RANDOM_ITEMS) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 12);
      bs = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 8191) & 13'h1F1F;
      if (w > 32 || w == 0) w = w & 13'h1F00;
      calm = (iter == 3);
      case ($urandom_range(0, 3))
        0: write_reg(bap_pkg::REG_REGION_WIDTH, 13'(w));
        1: write_reg(bap_pkg::REG_BLOCK_SIZE, 13'(bs));
        2: write_reg(REG_NONE, 13'($urandom_range(0, 8191)));
        default: set_region(13'(w), 13'(h), 13'(bs));
      endcase
      w = clip(shadow_width, 1, 4096);
      h = clip(shadow_height, 1, 4096);
      if (w * h > 300) h = clip(300 / w, 1, 4096);
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h)
                                          : w * h * $urandom_range(1, 2);
      if (pixels_sent + count > RANDOM_ITEMS) count = RANDOM_ITEMS - pixels_sent;
      repeat (count) send_random_pixel();
      iter++;
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (out_pop && !out_empty) begin
      if (pending_avgs.size() == 0) begin
        $display("%0t: unexpected result col %0d row %0d", $time, out_block_col,
                 out_block_row);
        errors++;
      end else begin
        bap_pkg::res_t want;
        want = pending_avgs.pop_front();
        if (out_avg_red !== want.red) begin
          $display("%0t: avg_red expected %0d actual %0d", $time, want.red, out_avg_red);
          errors++;
        end
        if (out_avg_green !== want.green) begin
          $display("%0t: avg_green expected %0d actual %0d", $time, want.green,
                   out_avg_green);
          errors++;
        end
        if (out_avg_blue !== want.blue) begin
          $display("%0t: avg_blue expected %0d actual %0d", $time, want.blue, out_avg_blue);
          errors++;
        end
        if (out_avg_alpha !== want.alpha) begin
          $display("%0t: avg_alpha expected %0d actual %0d", $time, want.alpha,
                   out_avg_alpha);
          errors++;
        end
        if (out_block_col !== want.bcol) begin
          $display("%0t: block_col expected %0d actual %0d", $time, want.bcol,
                   out_block_col);
          errors++;
        end
        if (out_block_row !== want.brow) begin
          $display("%0t: block_row expected %0d actual %0d", $time, want.brow,
                   out_block_row);
          errors++;
        end
        if (out_last_block !== want.last) begin
          $display("%0t: last_block expected %0d actual %0d", $time, want.last,
                   out_last_block);
          errors++;
        end
      end
    end
    if (hold_request && hold_left == 0) begin
      hold_request <= 1'b0;
      hold_left <= 400;
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= !take_break();
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("block_average_pixelate verification failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_pix_red = '0;
    in_pix_green = '0;
    in_pix_blue = '0;
    in_pix_alpha = '0;
    out_pop = 1'b0;
    errors = 0;
    pixels_sent = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    shadow_width = 64;
    shadow_height = 64;
    shadow_bsize = 8;
    next_col = 0;
    next_row = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_channel_extremes();
    test_out_of_range_regs();
    test_full_input_stall();
    test_random_regions();
    wait_drained();
    if (errors == 0) begin
      $display("block_average_pixelate verification clean");
    end else begin
      $display("block_average_pixelate verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/bap_pkg.sv
src/bap_ram.sv
src/bap_front.sv
src/bap_back.sv
src/block_average_pixelate.sv
sim/tb_block_average_pixelate.sv
